@@ src/hbsm_pkg.sv @@
// Package for the host blacklist substring matcher: sizes, mode codes,
// transaction and cell item types, and the ASCII case fold.
// No dependencies.
package hbsm_pkg;

    localparam int NUM_PATTERNS  = 16;
    localparam int PATTERN_BYTES = 32;

    // Fixed field widths of the transaction
    localparam int MODE_W  = 2;
    localparam int ENTRY_W = 4;
    localparam int POS_W   = 5;
    localparam int PLEN_W  = 6;
    localparam int CHAR_W  = 8;
    localparam int ACT_W   = 5;

    // Derived storage widths
    localparam int CELL_IDX_W = (NUM_PATTERNS > 1) ? $clog2(NUM_PATTERNS) : 1;
    localparam int BYTE_IDX_W = (PATTERN_BYTES > 1) ? $clog2(PATTERN_BYTES) : 1;
    localparam int LEN_W      = $clog2(PATTERN_BYTES + 1);

    // APB register map
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic [APB_ADDR_W-1:0] ADDR_ACTIVE = 3'd0;

    // Mode codes
    localparam logic [MODE_W-1:0] MODE_WRITE  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LENGTH = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SCAN   = 2'd2;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [ENTRY_W-1:0] entry;
        logic [POS_W-1:0]   position;
        logic [PLEN_W-1:0]  pattern_length;
        logic [CHAR_W-1:0]  char_byte;
        logic               last;
    } t_in_item;

    typedef struct packed {
        logic blacklisted;
    } t_out_item;

    // Transaction as it travels along the cell chain
    typedef struct packed {
        logic               valid;
        logic [MODE_W-1:0]  mode;
        logic [ENTRY_W-1:0] entry;
        logic [POS_W-1:0]   position;
        logic [PLEN_W-1:0]  pattern_length;
        logic [CHAR_W-1:0]  ch;     // already folded to lower case
        logic               last;
        logic               hit;    // OR of hits of cells passed so far
    } t_cell_item;

    function automatic logic [CHAR_W-1:0] fold_case(input logic [CHAR_W-1:0] c);
        if (c >= 8'd65 && c <= 8'd90) begin
            return c + 8'd32;
        end
        return c;
    endfunction

endpackage

@@ src/hbsm_if.sv @@
// Valid/ready channel interfaces for the input and result transactions.
// Depends on hbsm_pkg.
interface hbsm_in_if;
    import hbsm_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface hbsm_out_if;
    import hbsm_pkg::*;
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ src/hbsm_match_cell.sv @@
// One match cell: holds one pattern entry, its length and its partial-match
// vector, and hands each transaction on to the next cell. Depends on hbsm_pkg.
module hbsm_match_cell (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_en,
    input  logic [hbsm_pkg::CELL_IDX_W-1:0] i_index,
    input  logic [hbsm_pkg::ACT_W-1:0]      i_active,
    input  hbsm_pkg::t_cell_item            i_item,
    output hbsm_pkg::t_cell_item            o_item
);
    import hbsm_pkg::*;

    logic [CHAR_W-1:0]        r_bytes [PATTERN_BYTES];
    logic [LEN_W-1:0]         r_len;
    logic [PATTERN_BYTES-1:0] r_vec;
    logic                     r_hit;
    t_cell_item               r_item;

    logic [PATTERN_BYTES-1:0] n_vec;
    t_cell_item               n_item;
    logic [LEN_W-1:0]         w_len_m1;
    logic [LEN_W-1:0]         w_len_sat;
    logic                     w_match;
    logic                     w_cell_hit;
    logic                     w_mine;
    logic                     w_active;

    assign w_mine   = (32'(i_item.entry) == 32'(i_index));
    assign w_active = (32'(i_index) < 32'(i_active));

    always_comb begin
        for (int k = 0; k < PATTERN_BYTES; k++) begin
            n_vec[k] = (k < 32'(r_len))
                     && ((k == 0) ? 1'b1 : r_vec[(k == 0) ? 0 : k - 1])
                     && (r_bytes[k] == i_item.ch);
        end
    end

    assign w_len_m1   = r_len - LEN_W'(1);
    assign w_match    = (r_len == '0) || n_vec[w_len_m1[BYTE_IDX_W-1:0]];
    assign w_cell_hit = r_hit || (w_active && w_match);
    assign w_len_sat  = (32'(i_item.pattern_length) > PATTERN_BYTES)
                      ? LEN_W'(PATTERN_BYTES) : LEN_W'(i_item.pattern_length);

    // Fold this cell's finding into a passing host byte
    always_comb begin
        n_item = i_item;
        if (i_item.valid && i_item.mode == MODE_SCAN) begin
            n_item.hit = i_item.hit || w_cell_hit;
        end
    end

    // Pattern bytes need no reset
    always_ff @(posedge i_clk) begin
        if (i_en && i_item.valid && i_item.mode == MODE_WRITE && w_mine
                && 32'(i_item.position) < PATTERN_BYTES) begin
            r_bytes[i_item.position[BYTE_IDX_W-1:0]] <= i_item.ch;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len        <= '0;
            r_vec        <= '0;
            r_hit        <= 1'b0;
            r_item.valid <= 1'b0;
        end else if (i_en) begin
            r_item <= n_item;
            if (i_item.valid) begin
                unique case (i_item.mode)
                    MODE_LENGTH: begin
                        if (w_mine) begin
                            r_len <= w_len_sat;
                        end
                    end
                    MODE_SCAN: begin
                        if (i_item.last) begin
                            r_vec <= '0;
                            r_hit <= 1'b0;
                        end else begin
                            r_vec <= n_vec;
                            r_hit <= w_cell_hit;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    assign o_item = r_item;

endmodule

@@ src/host_blacklist_substring_match_core.sv @@
// Top level of the host blacklist substring matcher: APB register, input
// folding, the chain of match cells and the result register.
// Depends on hbsm_pkg, hbsm_if and hbsm_match_cell.

// Case-insensitive multi-pattern substring matcher. Every transaction (pattern
// byte write, pattern length write or host byte) enters a chain of
// NUM_PATTERNS match cells, one cell per pattern entry, and moves one cell per
// cycle, so one transaction is accepted every clock cycle while the chain is
// not stalled; the verdict for a host passes through the chain of cells and
// then the result register. Each cell compares the host byte against
// all bytes of its pattern at once and ORs its finding into the transaction as
// it passes. The result register decouples the output: the chain keeps
// accepting while a verdict waits, and only stalls when a second verdict
// reaches the end of the chain before the first is taken. Table writes travel
// in order with host bytes, so they take effect from the next host byte. The
// active_patterns register (APB address 0) must be written only while the
// chain is empty.
module host_blacklist_substring_match_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    hbsm_in_if.sink                         i_in,
    hbsm_out_if.source                      o_out,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [hbsm_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [hbsm_pkg::APB_DATA_W-1:0] pwdata,
    output logic [hbsm_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);
    import hbsm_pkg::*;

    logic [ACT_W-1:0] r_active;
    logic             r_ovalid;
    logic             r_ohit;

    t_cell_item w_chain [NUM_PATTERNS+1];
    logic       w_en;
    logic       w_tail_result;
    logic       w_reg_sel;

    // APB register: a single count of active entries, to be written only while idle (not enforced by the block)
    assign pready    = 1'b1;
    assign w_reg_sel = (paddr[APB_ADDR_W-1:2] == ADDR_ACTIVE[APB_ADDR_W-1:2]);
    assign prdata    = w_reg_sel ? APB_DATA_W'(r_active) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= '0;
        end else if (psel && penable && pwrite && pready && w_reg_sel) begin
            r_active <= pwdata[ACT_W-1:0];
        end
    end

    // Stall the chain only when a verdict at its tail has nowhere to go
    assign w_tail_result = w_chain[NUM_PATTERNS].valid
                        && w_chain[NUM_PATTERNS].mode == MODE_SCAN
                        && w_chain[NUM_PATTERNS].last;
    assign w_en       = !(w_tail_result && r_ovalid && !o_out.ready);
    assign i_in.ready = w_en;

    // Head of the chain: fold the byte to lower case once for every cell
    always_comb begin
        w_chain[0].valid          = i_in.valid && w_en;
        w_chain[0].mode           = i_in.data.mode;
        w_chain[0].entry          = i_in.data.entry;
        w_chain[0].position       = i_in.data.position;
        w_chain[0].pattern_length = i_in.data.pattern_length;
        w_chain[0].ch             = fold_case(i_in.data.char_byte);
        w_chain[0].last           = i_in.data.last;
        w_chain[0].hit            = 1'b0;
    end

    for (genvar g = 0; g < NUM_PATTERNS; g++) begin : g_cell
        hbsm_match_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_en     (w_en),
            .i_index  (CELL_IDX_W'(g)),
            .i_active (r_active),
            .i_item   (w_chain[g]),
            .o_item   (w_chain[g+1])
        );
    end

    // Result register: load a verdict from the tail, drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_en && w_tail_result) begin
            r_ovalid <= 1'b1;
        end else if (o_out.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en && w_tail_result) begin
            r_ohit <= w_chain[NUM_PATTERNS].hit;
        end
    end

    assign o_out.valid            = r_ovalid;
    assign o_out.data.blacklisted = r_ohit;

    // Input backpressure only arises from a held verdict
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> (o_out.valid && !o_out.ready))
        else $error("input stalled without a held verdict");

    // A new verdict comes only from a last host byte at the chain tail
    a_verdict_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out.valid) |-> $past(w_tail_result))
        else $error("verdict appeared without a last host byte");

    // A taken verdict with nothing behind it leaves the register empty
    a_verdict_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.ready && !w_tail_result) |=> !o_out.valid)
        else $error("verdict repeated");

endmodule

@@ test/host_blacklist_substring_match_core_test.sv @@
// Self-checking testbench for host_blacklist_substring_match_core: drives pattern
// loads and host byte streams, predicts each host verdict and checks the results.
// Depends on hbsm_pkg, hbsm_if and the core RTL under src.
module host_blacklist_substring_match_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import hbsm_pkg::*;

    localparam int CLK_PERIOD      = 10;
    localparam int RESET_CYCLES    = 12;
    // Chain depth plus result register, with margin, to flush transactions that
    // produce no verdict before touching the register.
    localparam int DRAIN_CYCLES    = 2 * NUM_PATTERNS + 8;
    localparam int IDLE_PCT        = 19;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int STALL_LIMIT     = 4000;
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    hbsm_in_if  in_if ();
    hbsm_out_if out_if ();

    host_blacklist_substring_match_core i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Shadow copy of the matcher: pattern table, per-entry partial match
    // vectors, the running hit of the current host and the register.
    // ------------------------------------------------------------------
    logic [CHAR_W-1:0]        table_bytes   [NUM_PATTERNS][PATTERN_BYTES];
    bit                       byte_written  [NUM_PATTERNS][PATTERN_BYTES];
    logic [PLEN_W-1:0]        table_lengths [NUM_PATTERNS];
    logic [PATTERN_BYTES-1:0] partial_vec   [NUM_PATTERNS];
    bit                       host_hit;
    logic [ACT_W-1:0]         active_reg;

    // Verdicts still owed by the block, oldest first
    bit pending_verdicts [$];

    int fail_count  = 0;
    int sent_items  = 0;
    int quiet_cycles = 0;
    bit steady      = 1'b0;  // no idling on either side while set
    bit hold_req    = 1'b0;  // ask the receiver for one long hold-off

    task automatic clear_shadow();
        foreach (table_bytes[p, k]) begin
            table_bytes[p][k]  = '0;
            byte_written[p][k] = 1'b0;
        end
        foreach (table_lengths[p]) begin
            table_lengths[p] = '0;
            partial_vec[p]   = '0;
        end
        host_hit   = 1'b0;
        active_reg = '0;
    endtask

    // Advance the shadow by one accepted transaction. A scan byte with last
    // pushes the verdict for the host.
    task automatic track_transaction(input t_in_item it);
        logic [CHAR_W-1:0]        ch;
        logic [PATTERN_BYTES-1:0] nxt;
        int                       act;
        int                       plen;
        bit                       hit;
        // ASCII upper case folds to lower case; every other byte is kept
        ch = (it.char_byte >= "A" && it.char_byte <= "Z") ? it.char_byte + 8'd32
                                                           : it.char_byte;
        case (it.mode)
            MODE_WRITE: begin
                if (it.entry < NUM_PATTERNS && it.position < PATTERN_BYTES) begin
                    table_bytes[it.entry][it.position]  = ch;
                    byte_written[it.entry][it.position] = 1'b1;
                end
            end
            MODE_LENGTH: begin
                if (it.entry < NUM_PATTERNS) begin
                    table_lengths[it.entry] = (it.pattern_length > PATTERN_BYTES) ?
                                              PLEN_W'(PATTERN_BYTES) : it.pattern_length;
                end
            end
            MODE_SCAN: begin
                act = (int'(active_reg) > NUM_PATTERNS) ? NUM_PATTERNS : int'(active_reg);
                hit = host_hit;
                for (int p = 0; p < NUM_PATTERNS; p++) begin
                    plen = int'(table_lengths[p]);
                    // Bit k: the first k+1 pattern bytes end at this host byte
                    for (int k = 0; k < PATTERN_BYTES; k++) begin
                        nxt[k] = (k < plen) && ((k == 0) ? 1'b1 : partial_vec[p][k-1])
                                 && (table_bytes[p][k] == ch);
                    end
                    partial_vec[p] = nxt;
                    if (p < act && (plen == 0 || nxt[plen-1])) begin
                        hit = 1'b1;
                    end
                end
                if (it.last) begin
                    pending_verdicts.push_back(hit);
                    foreach (partial_vec[p]) partial_vec[p] = '0;
                    host_hit = 1'b0;
                end else begin
                    host_hit = hit;
                end
            end
            default: ;  // unused mode: nothing changes
        endcase
    endtask

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------

    // Offer one transaction, idling first at random, and hold it until the
    // block takes it. Valid stays high on return so back-to-back items
    // never drop it.
    task automatic send_item(input t_in_item it);
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.data  <= it;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        track_transaction(it);
        if (it.mode != MODE_UNUSED) sent_items++;
    endtask

    // Every field random; callers then pin the fields their mode uses
    function automatic t_in_item random_item();
        t_in_item it;
        it.mode           = MODE_W'($urandom_range((1 << MODE_W) - 1));
        it.entry          = ENTRY_W'($urandom_range((1 << ENTRY_W) - 1));
        it.position       = POS_W'($urandom_range((1 << POS_W) - 1));
        it.pattern_length = PLEN_W'($urandom_range((1 << PLEN_W) - 1));
        it.char_byte      = CHAR_W'($urandom_range((1 << CHAR_W) - 1));
        it.last           = 1'($urandom_range(1));
        return it;
    endfunction

    // Mostly a small mixed-case alphabet so that hits are common
    function automatic logic [CHAR_W-1:0] pick_char();
        int r;
        r = $urandom_range(99);
        if (r < 40) return CHAR_W'("a" + $urandom_range(3));
        if (r < 70) return CHAR_W'("A" + $urandom_range(3));
        return CHAR_W'($urandom_range(255));
    endfunction

    task automatic send_write(input int e, input int pos, input logic [CHAR_W-1:0] c);
        t_in_item it;
        it          = random_item();
        it.mode     = MODE_WRITE;
        it.entry    = ENTRY_W'(e);
        it.position = POS_W'(pos);
        it.char_byte = c;
        send_item(it);
    endtask

    task automatic send_length(input int e, input int len);
        t_in_item it;
        it                = random_item();
        it.mode           = MODE_LENGTH;
        it.entry          = ENTRY_W'(e);
        it.pattern_length = PLEN_W'(len);
        send_item(it);
    endtask

    task automatic send_scan(input logic [CHAR_W-1:0] c, input bit last);
        t_in_item it;
        it           = random_item();
        it.mode      = MODE_SCAN;
        it.char_byte = c;
        it.last      = last;
        send_item(it);
    endtask

    // Write bytes 0..n-1 of an entry, then its length. A full pattern may get
    // a length beyond the table width, which must saturate.
    task automatic load_pattern(input int e, input int n);
        for (int k = 0; k < n; k++) send_write(e, k, pick_char());
        send_length(e, (n == PATTERN_BYTES && $urandom_range(1)) ?
                       int'($urandom_range(PATTERN_BYTES, (1 << PLEN_W) - 1)) : n);
    endtask

    // Stray transaction: unused mode, a write anywhere, a length that stays
    // within the written prefix of its entry, or a scan byte without last.
    task automatic send_noise();
        t_in_item it;
        int       prefix;
        it = random_item();
        case ($urandom_range(3))
            0: it.mode = MODE_UNUSED;
            1: it.mode = MODE_WRITE;
            2: begin
                it.mode = MODE_LENGTH;
                prefix  = 0;
                while (prefix < PATTERN_BYTES && byte_written[it.entry][prefix]) prefix++;
                if (prefix == PATTERN_BYTES && $urandom_range(1)) begin
                    it.pattern_length =
                        PLEN_W'($urandom_range(PATTERN_BYTES, (1 << PLEN_W) - 1));
                end else begin
                    it.pattern_length =
                        (prefix == 0) ? '0 : PLEN_W'($urandom_range(1, prefix));
                end
            end
            default: begin
                it.mode = MODE_SCAN;
                it.last = 1'b0;
            end
        endcase
        send_item(it);
    endtask

    // One host name; optionally plant an active pattern in it with random
    // case. Now and then a stray transaction lands in the middle of the host.
    task automatic send_host(input int n_bytes, input bit plant);
        logic [CHAR_W-1:0] host [$];
        logic [CHAR_W-1:0] c;
        int                act;
        int                e;
        int                plen;
        int                at;
        for (int i = 0; i < n_bytes; i++) host.push_back(pick_char());
        act = (int'(active_reg) > NUM_PATTERNS) ? NUM_PATTERNS : int'(active_reg);
        if (plant && act > 0) begin
            e    = $urandom_range(act - 1);
            plen = int'(table_lengths[e]);
            while (host.size() < plen) host.push_back(pick_char());
            at = $urandom_range(host.size() - plen);
            for (int k = 0; k < plen; k++) begin
                c = table_bytes[e][k];
                if (c >= "a" && c <= "z" && $urandom_range(1)) c = c - 8'd32;
                host[at + k] = c;
            end
        end
        foreach (host[i]) begin
            if ($urandom_range(99) < 4) send_noise();
            send_scan(host[i], i == host.size() - 1);
        end
    endtask

    // Drop valid, wait for every verdict, then let the chain drain
    task automatic wait_idle();
        in_if.valid <= 1'b0;
        while (pending_verdicts.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Register port: write active_patterns, then read it back
    // ------------------------------------------------------------------
    task automatic set_active(input logic [ACT_W-1:0] value);
        logic [APB_DATA_W-1:0] rd;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_ACTIVE;
        pwdata  <= APB_DATA_W'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        active_reg = value;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        psel   <= 1'b1;
        pwrite <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        rd = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        if (rd !== APB_DATA_W'(value)) begin
            $display("%0t: active_patterns readback expected %0d, got %0d",
                     $time, value, rd);
            fail_count++;
        end
    endtask

    // ------------------------------------------------------------------
    // Output side: random ready, plus one long hold-off on request
    // ------------------------------------------------------------------
    initial begin
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                out_if.ready <= 1'b0;
                for (int n = 0; n < HOLD_OFF_CYCLES; n++) @(posedge i_clk);
                hold_req = 1'b0;
            end else begin
                out_if.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // Compare each result transaction with the oldest owed verdict
    always @(posedge i_clk) begin
        bit expected_flag;
        if (i_rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
            if (pending_verdicts.size() == 0) begin
                $display("%0t: blacklisted expected none, got %0b",
                         $time, out_if.data.blacklisted);
                fail_count++;
            end else begin
                expected_flag = pending_verdicts.pop_front();
                if (out_if.data.blacklisted !== expected_flag) begin
                    $display("%0t: blacklisted expected %0b, got %0b",
                             $time, expected_flag, out_if.data.blacklisted);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: end the run if no transaction moves for too long
    always @(posedge i_clk) begin
        if ((in_if.valid === 1'b1 && in_if.ready === 1'b1) ||
            (out_if.valid === 1'b1 && out_if.ready === 1'b1)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Register extremes and readback
    task automatic test_register_access();
        set_active('0);
        set_active('1);
        set_active(ACT_W'(NUM_PATTERNS));
    endtask

    task automatic test_directed_cases();
        t_in_item it;
        wait_idle();
        set_active(ACT_W'(1));
        // Entry 0 holds "ab", loaded in mixed case
        send_write(0, 0, "A");
        send_write(0, 1, "b");
        send_length(0, 2);
        // Host in upper case still hits
        send_scan("x", 1'b0);
        send_scan("A", 1'b0);
        send_scan("B", 1'b1);
        // One-byte host, no hit
        send_scan("a", 1'b1);
        // Byte extremes, no hit
        send_scan(8'h00, 1'b0);
        send_scan(8'hFF, 1'b1);
        // Unused mode is dropped even with last high
        it      = random_item();
        it.mode = MODE_UNUSED;
        it.last = 1'b1;
        send_item(it);
        // last has no effect on a write; top entry and top position,
        // and the bytes just outside the letter range
        it           = random_item();
        it.mode      = MODE_WRITE;
        it.entry     = ENTRY_W'(NUM_PATTERNS - 1);
        it.position  = POS_W'(PATTERN_BYTES - 1);
        it.char_byte = 8'hFF;
        it.last      = 1'b1;
        send_item(it);
        it.position  = '0;
        it.char_byte = "@";
        send_item(it);
        it.position  = POS_W'(1);
        it.char_byte = "[";
        send_item(it);
        // Shrink the length mid-host: vectors are masked, the new length
        // applies from the next byte, so "a" then "b" gives no hit
        send_scan("a", 1'b0);
        send_length(0, 1);
        send_scan("b", 1'b1);
        send_length(0, 2);
        // Entry 1 still has length zero: an empty pattern matches any host
        wait_idle();
        set_active(ACT_W'(2));
        send_scan("z", 1'b1);
    endtask

    task automatic run_random_phase(input int n_items, input logic [ACT_W-1:0] act);
        int start;
        int r;
        int n;
        wait_idle();
        set_active(act);
        start = sent_items;
        while (sent_items - start < n_items) begin
            r = $urandom_range(99);
            if (r < 18) begin
                r = $urandom_range(99);
                n = (r < 2) ? 0 : (r < 12) ? PATTERN_BYTES : int'($urandom_range(1, 6));
                load_pattern($urandom_range(NUM_PATTERNS - 1), n);
            end else if (r < 90) begin
                send_host(($urandom_range(99) < 85) ? $urandom_range(1, 8)
                                                    : $urandom_range(9, 40),
                          1'($urandom_range(1)));
            end else begin
                send_noise();
            end
        end
    endtask

    task automatic test_random_traffic();
        // Give every entry a non-empty pattern so that full activity still
        // yields misses, and one entry the full width
        for (int e = 0; e < NUM_PATTERNS; e++) load_pattern(e, $urandom_range(2, 5));
        load_pattern($urandom_range(NUM_PATTERNS - 1), PATTERN_BYTES);
        run_random_phase(200, ACT_W'(NUM_PATTERNS));
        run_random_phase(200, '1);
        run_random_phase(200, ACT_W'(1));
        run_random_phase(200, '0);
        run_random_phase(200, ACT_W'($urandom_range(2, NUM_PATTERNS - 1)));
        run_random_phase(200, ACT_W'(NUM_PATTERNS));
    endtask

    // Both sides at full rate
    task automatic test_no_idling();
        steady = 1'b1;
        run_random_phase(250, ACT_W'(NUM_PATTERNS));
        steady = 1'b0;
    endtask

    // Hold the receiver off while short hosts keep coming, so verdicts back
    // up through the chain and the input stalls
    task automatic test_output_hold_off();
        wait_idle();
        set_active(ACT_W'(NUM_PATTERNS));
        hold_req = 1'b1;
        for (int i = 0; i < 80; i++) send_host($urandom_range(1, 2), 1'($urandom_range(1)));
    endtask

    initial begin
        i_rst_n     <= 1'b0;
        psel        <= 1'b0;
        penable     <= 1'b0;
        pwrite      <= 1'b0;
        paddr       <= '0;
        pwdata      <= '0;
        in_if.valid <= 1'b0;
        in_if.data  <= '0;
        clear_shadow();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_register_access();
        test_directed_cases();
        test_random_traffic();
        test_no_idling();
        test_output_hold_off();

        wait_idle();
        if (pending_verdicts.size() != 0) begin
            $display("%0t: %0d verdicts expected, none delivered",
                     $time, pending_verdicts.size());
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
